// ===== design/etbg_pkg.sv =====
// shared types and constants of the enveloped tone burst generator
package etbg_pkg;

  // configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BURST_LENGTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_STEP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_START = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_STEP  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE     = 3'd5;

  // configuration reset values
  localparam logic [31:0] RST_PHASE_STEP    = 32'd136348168;
  localparam logic [10:0] RST_BURST_LENGTH  = 11'd1984;
  localparam logic [15:0] RST_ATTACK_STEP   = 16'd248;
  localparam logic [10:0] RST_RELEASE_START = 11'd1103;
  localparam logic [15:0] RST_RELEASE_STEP  = 16'd37;
  localparam logic [14:0] RST_AMPLITUDE     = 15'd32000;

  // envelope full scale (1.0 in q1.15) and sine peak
  localparam logic [16:0] ENV_ONE    = 17'd32768;
  localparam logic [15:0] SINE_PEAK  = 16'd32767;

  // q30 constants for building the quarter-wave table
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // request queue depth between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration register set
  typedef struct packed {
    logic [31:0] phase_step;
    logic [10:0] burst_length;
    logic [15:0] attack_step;
    logic [10:0] release_start;
    logic [15:0] release_step;
    logic [14:0] amplitude;
  } cfg_t;

  // control flags of one queued sample job
  typedef struct packed {
    logic active;
    logic last;
    logic neg;
    logic peak;
  } job_ctl_t;

endpackage

// ===== design/etbg_channels.sv =====
// handshake channel interfaces: input tick, result sample, configuration write
interface etbg_in_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface etbg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        active;
  logic        last;

  modport source (output valid, output sample, output active, output last, input ready);
  modport sink (input valid, input sample, input active, input last, output ready);
endinterface

interface etbg_cfg_if;
  import etbg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/etbg_front.sv =====
// front end: accepts ticks, advances phase, index and envelope, emits sample jobs
module etbg_front #(
  parameter int LUT_DEPTH   = 256,
  parameter int PHASE_WIDTH = 32,
  parameter int AW          = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  etbg_in_if.sink             in_ch,
  input  etbg_pkg::cfg_t      cfg,
  input  logic                q_full,
  output logic                push,
  output etbg_pkg::job_ctl_t  job_ctl,
  output logic [15:0]         job_env,
  output logic [AW-1:0]       job_addr
);
  import etbg_pkg::*;

  localparam int PW = PHASE_WIDTH;
  localparam int PRODW = PW + AW - 1;

  logic [PW-1:0] phase_r, phase_nxt;
  logic [10:0]   index_r, index_nxt;
  logic [15:0]   env_r, env_nxt;
  logic          running_r, running_nxt;

  logic          accept;
  logic          run_eff;
  logic [PW-1:0] phase_eff;
  logic [10:0]   index_eff;
  logic [15:0]   env_eff;
  logic [1:0]    quad;
  logic [PRODW-1:0] idx_prod;
  logic [AW-1:0] idx;
  logic [AW:0]   mirror;
  logic          is_last;
  logic [16:0]   env_sum;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && !q_full;

  // state as seen by this request, after a start request
  assign run_eff   = in_ch.start_req || running_r;
  assign phase_eff = in_ch.start_req ? '0 : phase_r;
  assign index_eff = in_ch.start_req ? '0 : index_r;
  assign env_eff   = in_ch.start_req ? '0 : env_r;

  // table address from the phase: quadrant and scaled fraction
  assign quad     = phase_eff[PW-1:PW-2];
  assign idx_prod = PRODW'(phase_eff[PW-3:0]) * PRODW'(LUT_DEPTH);
  assign idx      = idx_prod[PW+AW-3:PW-2];
  assign mirror   = (AW+1)'(LUT_DEPTH) - {1'b0, idx};

  assign is_last = (index_eff == (cfg.burst_length - 11'd1));

  // job toward the back end
  always_comb begin
    push             = accept;
    job_ctl.active   = run_eff;
    job_ctl.last     = run_eff && is_last;
    job_ctl.neg      = run_eff && quad[1];
    job_ctl.peak     = quad[0] && (idx == '0);
    job_env          = run_eff ? env_eff : 16'd0;
    job_addr         = quad[0] ? mirror[AW-1:0] : idx;
  end

  // next burst state
  always_comb begin
    phase_nxt   = phase_r;
    index_nxt   = index_r;
    env_nxt     = env_r;
    running_nxt = running_r;
    env_sum     = {1'b0, env_eff} + {1'b0, cfg.attack_step};
    if (accept && run_eff) begin
      phase_nxt   = phase_eff + PW'(cfg.phase_step);
      index_nxt   = index_eff + 11'd1;
      running_nxt = !is_last;
      if (index_nxt >= cfg.release_start) begin
        env_nxt = (env_eff > cfg.release_step) ? env_eff - cfg.release_step : 16'd0;
      end else begin
        env_nxt = (env_sum > ENV_ONE) ? ENV_ONE[15:0] : env_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      index_r   <= '0;
      env_r     <= '0;
      running_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      index_r   <= index_nxt;
      env_r     <= env_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

// ===== design/etbg_queue.sv =====
// short request queue between front and back end
module etbg_queue #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNTW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/etbg_back.sv =====
// back end: sine table read, envelope and amplitude scaling, sign, output register
module etbg_back #(
  parameter int LUT_DEPTH = 256,
  parameter int AW        = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  etbg_pkg::job_ctl_t  q_ctl,
  input  logic [15:0]         q_env,
  input  logic [AW-1:0]       q_addr,
  output logic                pop,
  input  logic [14:0]         amplitude,
  etbg_out_if.source          out_ch
);
  import etbg_pkg::*;

  // quarter-wave sine, q30 odd polynomial through x^11, rounded to q15
  function automatic logic [15:0] sine_value(input int i);
    logic [63:0] x, x2, t, s, q;
    x  = (64'(i) * HALF_PI_Q30) / 64'(LUT_DEPTH);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s + (64'd1 << 14)) >> 15;
    if (q > 64'(SINE_PEAK)) begin
      q = 64'(SINE_PEAK);
    end
    return q[15:0];
  endfunction

  logic [15:0] sine_rom [LUT_DEPTH];

  // constant table, one entry per address
  for (genvar g = 0; g < LUT_DEPTH; g++) begin : g_sine_rom
    localparam logic [15:0] SINE_VAL = sine_value(g);
    assign sine_rom[g] = SINE_VAL;
  end

  logic        advance;

  logic        s1_valid_r;
  job_ctl_t    s1_ctl_r;
  logic [15:0] s1_env_r;
  logic [15:0] s1_sine_r;

  logic        s2_valid_r;
  job_ctl_t    s2_ctl_r;
  logic [14:0] s2_mag_r;

  logic        out_valid_r;
  logic [15:0] out_sample_r;
  logic        out_active_r;
  logic        out_last_r;

  logic [31:0] env_prod;
  logic [29:0] amp_prod;
  logic [15:0] mag_ext;

  // whole pipeline moves when the output register is free or being taken
  assign advance = !out_valid_r || out_ch.ready;
  assign pop     = advance && q_not_empty;

  assign env_prod = {16'd0, s1_sine_r} * {16'd0, s1_env_r};
  assign amp_prod = {15'd0, s2_mag_r} * {15'd0, amplitude};
  assign mag_ext  = {1'b0, amp_prod[29:15]};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= q_not_empty;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl_r     <= q_ctl;
      s1_env_r     <= q_env;
      s1_sine_r    <= q_ctl.peak ? SINE_PEAK : sine_rom[q_addr];
      s2_ctl_r     <= s1_ctl_r;
      s2_mag_r     <= env_prod[29:15];
      out_sample_r <= s2_ctl_r.neg ? (16'd0 - mag_ext) : mag_ext;
      out_active_r <= s2_ctl_r.active;
      out_last_r   <= s2_ctl_r.last;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;
  assign out_ch.active = out_active_r;
  assign out_ch.last   = out_last_r;

endmodule

// ===== design/enveloped_tone_burst_generator.sv =====
// top level: configuration registers, front end, request queue, back end
// an accepted sample request passes through the request queue, then the s1, s2 and output registers
// throughput: one request per cycle, held up only when the result side stalls
// the front end state update adds to phase and index and steps the envelope up or down per request
// reset (synchronous, rst_n low): idle, no burst running, registers at defaults,
// queue and pipeline empty; no clearing pass
module enveloped_tone_burst_generator #(
  parameter int LUT_DEPTH   = 256,
  parameter int PHASE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  etbg_in_if.sink     in_ch,
  etbg_out_if.source  out_ch,
  etbg_cfg_if.sink    cfg_ch
);
  import etbg_pkg::*;

  localparam int AW   = $clog2(LUT_DEPTH);
  localparam int CTLW = $bits(job_ctl_t);
  localparam int QW   = CTLW + 16 + AW;

  cfg_t          cfg_r, cfg_nxt;

  logic          push;
  job_ctl_t      f_ctl;
  logic [15:0]   f_env;
  logic [AW-1:0] f_addr;
  logic          q_full;
  logic          q_not_empty;
  logic          pop;
  logic [QW-1:0] q_data;
  job_ctl_t      b_ctl;
  logic [15:0]   b_env;
  logic [AW-1:0] b_addr;

  // configuration writes, unknown indexes ignored
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PHASE_STEP:    cfg_nxt.phase_step    = cfg_ch.data[31:0];
        CFG_BURST_LENGTH:  cfg_nxt.burst_length  = cfg_ch.data[10:0];
        CFG_ATTACK_STEP:   cfg_nxt.attack_step   = cfg_ch.data[15:0];
        CFG_RELEASE_START: cfg_nxt.release_start = cfg_ch.data[10:0];
        CFG_RELEASE_STEP:  cfg_nxt.release_step  = cfg_ch.data[15:0];
        CFG_AMPLITUDE:     cfg_nxt.amplitude     = cfg_ch.data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step    <= RST_PHASE_STEP;
      cfg_r.burst_length  <= RST_BURST_LENGTH;
      cfg_r.attack_step   <= RST_ATTACK_STEP;
      cfg_r.release_start <= RST_RELEASE_START;
      cfg_r.release_step  <= RST_RELEASE_STEP;
      cfg_r.amplitude     <= RST_AMPLITUDE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end
  etbg_front #(
    .LUT_DEPTH   (LUT_DEPTH),
    .PHASE_WIDTH (PHASE_WIDTH),
    .AW          (AW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .job_ctl  (f_ctl),
    .job_env  (f_env),
    .job_addr (f_addr)
  );

  // request queue
  etbg_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_ctl, f_env, f_addr}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  assign b_ctl  = q_data[QW-1:QW-CTLW];
  assign b_env  = q_data[AW+15:AW];
  assign b_addr = q_data[AW-1:0];

  // back end
  etbg_back #(
    .LUT_DEPTH (LUT_DEPTH),
    .AW        (AW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_ctl       (b_ctl),
    .q_env       (b_env),
    .q_addr      (b_addr),
    .pop         (pop),
    .amplitude   (cfg_r.amplitude),
    .out_ch      (out_ch)
  );

endmodule
